/* rtl/tec_pkg.sv */
// Shared constants for the triangle edge crossing test core.
// No dependencies; imported by every module of the core.
`default_nettype none
package tec_pkg;
   localparam int FIELD_BITS = 32;  // width of one coordinate port
   localparam int NUM_VERT   = 3;   // vertices (and edges) per triangle
   localparam int NUM_PAIR   = 9;   // edge pairs, and vertex pairs, A x B
   localparam int SCALE_BITS = 14;  // 10000 < 2**14
   // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4
   localparam int SCALE_SH0  = 13;
   localparam int SCALE_SH1  = 10;
   localparam int SCALE_SH2  = 9;
   localparam int SCALE_SH3  = 8;
   localparam int SCALE_SH4  = 4;
endpackage
`default_nettype wire

/* rtl/tec_diff.sv */
// Stages 0 and 1: coordinate capture and all edge / vertex-pair differences.
// Depends on tec_pkg.
`default_nettype none
module tec_diff #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                valid_in,
   input  wire logic [tec_pkg::FIELD_BITS-1:0]      ax [tec_pkg::NUM_VERT],
   input  wire logic [tec_pkg::FIELD_BITS-1:0]      ay [tec_pkg::NUM_VERT],
   input  wire logic [tec_pkg::FIELD_BITS-1:0]      bx [tec_pkg::NUM_VERT],
   input  wire logic [tec_pkg::FIELD_BITS-1:0]      by [tec_pkg::NUM_VERT],
   output logic                                     valid_out,
   output logic signed [COORD_BITS:0]               eax [tec_pkg::NUM_VERT],
   output logic signed [COORD_BITS:0]               eay [tec_pkg::NUM_VERT],
   output logic signed [COORD_BITS:0]               ebx [tec_pkg::NUM_VERT],
   output logic signed [COORD_BITS:0]               eby [tec_pkg::NUM_VERT],
   output logic signed [COORD_BITS:0]               dx  [tec_pkg::NUM_PAIR],
   output logic signed [COORD_BITS:0]               dy  [tec_pkg::NUM_PAIR]
);
   import tec_pkg::*;
   localparam int CW = COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] ax_in [NUM_VERT], ay_in [NUM_VERT];
   logic signed [COORD_BITS-1:0] bx_in [NUM_VERT], by_in [NUM_VERT];
   logic signed [COORD_BITS-1:0] ax_ff [NUM_VERT], ay_ff [NUM_VERT];
   logic signed [COORD_BITS-1:0] bx_ff [NUM_VERT], by_ff [NUM_VERT];
   logic signed [CW-1:0] eax_ff [NUM_VERT], eay_ff [NUM_VERT];
   logic signed [CW-1:0] ebx_ff [NUM_VERT], eby_ff [NUM_VERT];
   logic signed [CW-1:0] dx_ff [NUM_PAIR], dy_ff [NUM_PAIR];
   logic v0_ff, v1_ff;

   genvar i, j;
   generate
      for (i = 0; i < NUM_VERT; i++) begin : g_vert
         // coordinate = low COORD_BITS of the field, or the field sign-extended when COORD_BITS is wider
         if (COORD_BITS <= FIELD_BITS) begin : g_trunc
            assign ax_in[i] = ax[i][COORD_BITS-1:0];
            assign ay_in[i] = ay[i][COORD_BITS-1:0];
            assign bx_in[i] = bx[i][COORD_BITS-1:0];
            assign by_in[i] = by[i][COORD_BITS-1:0];
         end else begin : g_ext
            assign ax_in[i] = {{(COORD_BITS-FIELD_BITS){ax[i][FIELD_BITS-1]}}, ax[i]};
            assign ay_in[i] = {{(COORD_BITS-FIELD_BITS){ay[i][FIELD_BITS-1]}}, ay[i]};
            assign bx_in[i] = {{(COORD_BITS-FIELD_BITS){bx[i][FIELD_BITS-1]}}, bx[i]};
            assign by_in[i] = {{(COORD_BITS-FIELD_BITS){by[i][FIELD_BITS-1]}}, by[i]};
         end

         always_ff @(posedge clock) begin
            ax_ff[i] <= ax_in[i];
            ay_ff[i] <= ay_in[i];
            bx_ff[i] <= bx_in[i];
            by_ff[i] <= by_in[i];
            eax_ff[i] <= CW'(ax_ff[(i+1)%NUM_VERT]) - CW'(ax_ff[i]);
            eay_ff[i] <= CW'(ay_ff[(i+1)%NUM_VERT]) - CW'(ay_ff[i]);
            ebx_ff[i] <= CW'(bx_ff[(i+1)%NUM_VERT]) - CW'(bx_ff[i]);
            eby_ff[i] <= CW'(by_ff[(i+1)%NUM_VERT]) - CW'(by_ff[i]);
         end

         for (j = 0; j < NUM_VERT; j++) begin : g_pair
            // d(i,j) = B vertex j minus A vertex i
            always_ff @(posedge clock) begin
               dx_ff[i*NUM_VERT+j] <= CW'(bx_ff[j]) - CW'(ax_ff[i]);
               dy_ff[i*NUM_VERT+j] <= CW'(by_ff[j]) - CW'(ay_ff[i]);
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= valid_in;
         v1_ff <= v0_ff;
      end
   end

   assign valid_out = v1_ff;
   assign eax = eax_ff;
   assign eay = eay_ff;
   assign ebx = ebx_ff;
   assign eby = eby_ff;
   assign dx  = dx_ff;
   assign dy  = dy_ff;
endmodule
`default_nettype wire

/* rtl/tec_prod.sv */
// Stages 2 and 3: squares and cross-product terms, then sums, skip limits, turn flags.
// Depends on tec_pkg.
`default_nettype none
module tec_prod #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          valid_in,
   input  wire logic signed [COORD_BITS:0]    eax [tec_pkg::NUM_VERT],
   input  wire logic signed [COORD_BITS:0]    eay [tec_pkg::NUM_VERT],
   input  wire logic signed [COORD_BITS:0]    ebx [tec_pkg::NUM_VERT],
   input  wire logic signed [COORD_BITS:0]    eby [tec_pkg::NUM_VERT],
   input  wire logic signed [COORD_BITS:0]    dx  [tec_pkg::NUM_PAIR],
   input  wire logic signed [COORD_BITS:0]    dy  [tec_pkg::NUM_PAIR],
   output logic                               valid_out,
   output logic [2*COORD_BITS+2:0]            dsq [tec_pkg::NUM_PAIR],
   output logic [2*COORD_BITS+2:0]            lim  [tec_pkg::NUM_PAIR],
   output logic                               left_a  [tec_pkg::NUM_PAIR],
   output logic                               right_b [tec_pkg::NUM_PAIR]
);
   import tec_pkg::*;
   localparam int CW = COORD_BITS + 1;
   localparam int PW = 2 * CW;
   localparam int DW = PW + 1;

   logic [PW-1:0] sqx_ff [NUM_PAIR], sqy_ff [NUM_PAIR];
   logic [PW-1:0] lax_ff [NUM_VERT], lay_ff [NUM_VERT];
   logic [PW-1:0] lbx_ff [NUM_VERT], lby_ff [NUM_VERT];
   // cross(ea_i, d(i,j)) terms and cross(eb_j, d(i,j)) terms
   logic signed [PW-1:0] pa0_ff [NUM_PAIR], pa1_ff [NUM_PAIR];
   logic signed [PW-1:0] pb0_ff [NUM_PAIR], pb1_ff [NUM_PAIR];
   logic [DW-1:0] la_in [NUM_VERT], lb_in [NUM_VERT];
   logic [DW-1:0] dist_ff [NUM_PAIR], lim_ff [NUM_PAIR];
   logic signed [DW-1:0] ca_in [NUM_PAIR], cb_in [NUM_PAIR];
   logic left_a_ff [NUM_PAIR], right_b_ff [NUM_PAIR];
   logic v2_ff, v3_ff;

   genvar i, j;
   generate
      for (i = 0; i < NUM_VERT; i++) begin : g_edge
         always_ff @(posedge clock) begin
            lax_ff[i] <= PW'(eax[i] * eax[i]);
            lay_ff[i] <= PW'(eay[i] * eay[i]);
            lbx_ff[i] <= PW'(ebx[i] * ebx[i]);
            lby_ff[i] <= PW'(eby[i] * eby[i]);
         end
         assign la_in[i] = DW'(lax_ff[i]) + DW'(lay_ff[i]);
         assign lb_in[i] = DW'(lbx_ff[i]) + DW'(lby_ff[i]);
      end

      for (i = 0; i < NUM_VERT; i++) begin : g_a
         for (j = 0; j < NUM_VERT; j++) begin : g_b
            localparam int K = i * NUM_VERT + j;
            always_ff @(posedge clock) begin
               sqx_ff[K] <= PW'(dx[K] * dx[K]);
               sqy_ff[K] <= PW'(dy[K] * dy[K]);
               pa0_ff[K] <= eax[i] * dy[K];
               pa1_ff[K] <= eay[i] * dx[K];
               pb0_ff[K] <= ebx[j] * dy[K];
               pb1_ff[K] <= eby[j] * dx[K];
            end
            assign ca_in[K] = DW'(pa0_ff[K]) - DW'(pa1_ff[K]);
            assign cb_in[K] = DW'(pb0_ff[K]) - DW'(pb1_ff[K]);
            always_ff @(posedge clock) begin
               dist_ff[K] <= DW'(sqx_ff[K]) + DW'(sqy_ff[K]);
               lim_ff[K]  <= (la_in[i] < lb_in[j]) ? la_in[i] : lb_in[j];
               // A sees B vertex j to the left: cross > 0
               left_a_ff[K]  <= !ca_in[K][DW-1] && (|ca_in[K]);
               // B sees A vertex i to the left: cross(eb, -d) > 0
               right_b_ff[K] <= cb_in[K][DW-1];
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v2_ff <= valid_in;
         v3_ff <= v2_ff;
      end
   end

   assign valid_out = v3_ff;
   assign dsq     = dist_ff;
   assign lim     = lim_ff;
   assign left_a  = left_a_ff;
   assign right_b = right_b_ff;
endmodule
`default_nettype wire

/* rtl/tec_skip.sv */
// Stages 4 and 5: scale squared distances by 10000, apply the skip test, decide each pair.
// Depends on tec_pkg.
`default_nettype none
module tec_skip #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        valid_in,
   input  wire logic [2*COORD_BITS+2:0]     dsq [tec_pkg::NUM_PAIR],
   input  wire logic [2*COORD_BITS+2:0]     lim  [tec_pkg::NUM_PAIR],
   input  wire logic                        left_a  [tec_pkg::NUM_PAIR],
   input  wire logic                        right_b [tec_pkg::NUM_PAIR],
   output logic                             valid_out,
   output logic [tec_pkg::NUM_PAIR-1:0]     hit
);
   import tec_pkg::*;
   localparam int DW = 2 * COORD_BITS + 3;
   localparam int SW = DW + SCALE_BITS;

   logic [SW-1:0] sd_ff [NUM_PAIR];
   logic [DW-1:0] lim_ff [NUM_PAIR];
   logic left_a_ff [NUM_PAIR], right_b_ff [NUM_PAIR];
   logic [NUM_PAIR-1:0] hit_ff;
   logic v4_ff, v5_ff;

   genvar i, j;
   generate
      for (i = 0; i < NUM_PAIR; i++) begin : g_scale
         always_ff @(posedge clock) begin
            sd_ff[i] <= (SW'(dsq[i]) << SCALE_SH0) + (SW'(dsq[i]) << SCALE_SH1)
                      + (SW'(dsq[i]) << SCALE_SH2) + (SW'(dsq[i]) << SCALE_SH3)
                      + (SW'(dsq[i]) << SCALE_SH4);
            lim_ff[i]     <= lim[i];
            left_a_ff[i]  <= left_a[i];
            right_b_ff[i] <= right_b[i];
         end
      end

      for (i = 0; i < NUM_VERT; i++) begin : g_a
         for (j = 0; j < NUM_VERT; j++) begin : g_b
            localparam int K   = i * NUM_VERT + j;
            localparam int KJ  = i * NUM_VERT + (j + 1) % NUM_VERT;
            localparam int KI  = ((i + 1) % NUM_VERT) * NUM_VERT + j;
            localparam int KIJ = ((i + 1) % NUM_VERT) * NUM_VERT + (j + 1) % NUM_VERT;
            logic near;
            assign near = (sd_ff[K]   < SW'(lim_ff[K])) || (sd_ff[KJ]  < SW'(lim_ff[K]))
                       || (sd_ff[KI]  < SW'(lim_ff[K])) || (sd_ff[KIJ] < SW'(lim_ff[K]));
            always_ff @(posedge clock) begin
               hit_ff[K] <= !near && (left_a_ff[K] != left_a_ff[KJ])
                                  && (right_b_ff[K] != right_b_ff[KI]);
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= valid_in;
         v5_ff <= v4_ff;
      end
   end

   assign valid_out = v5_ff;
   assign hit       = hit_ff;
endmodule
`default_nettype wire

/* rtl/triangle_edge_crossing_test_core.sv */
// Top level of the triangle edge crossing test: pipeline stages and result register.
// Depends on tec_pkg, tec_diff, tec_prod, tec_skip.
//
//   channel | ports                         | transfer when
//   --------+-------------------------------+-------------------------
//   request | start, busy, req_a_*, req_b_* | start high, busy low
//   result  | rsp_valid, rsp_overlap        | rsp_valid high (1 cycle)
//
// Fully pipelined: one triangle pair may enter every cycle; busy stays low.
// Stages: capture, differences, products, sums/limits/turn flags, x10000
// scale, per-pair decision, OR of the nine pairs.
// Synchronous active-high reset clears only the valid bits; payload is not reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
`default_nettype none
module triangle_edge_crossing_test_core #(
   parameter int COORD_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_a_x0,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_a_y0,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_a_x1,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_a_y1,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_a_x2,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_a_y2,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_b_x0,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_b_y0,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_b_x1,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_b_y1,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_b_x2,
   input  wire logic signed [tec_pkg::FIELD_BITS-1:0] req_b_y2,
   output logic                                   rsp_valid,
   output logic                                   rsp_overlap
);
   import tec_pkg::*;
   localparam int CW = COORD_BITS + 1;
   localparam int DW = 2 * CW + 1;

   logic [FIELD_BITS-1:0] ax [NUM_VERT], ay [NUM_VERT];
   logic [FIELD_BITS-1:0] bx [NUM_VERT], by [NUM_VERT];
   logic accept;

   // stage 1 -> 2
   logic v1;
   logic signed [CW-1:0] eax [NUM_VERT], eay [NUM_VERT];
   logic signed [CW-1:0] ebx [NUM_VERT], eby [NUM_VERT];
   logic signed [CW-1:0] dx [NUM_PAIR], dy [NUM_PAIR];
   // stage 3 -> 4
   logic v3;
   logic [DW-1:0] dsq [NUM_PAIR], lim [NUM_PAIR];
   logic left_a [NUM_PAIR], right_b [NUM_PAIR];
   // stage 5 -> 6
   logic v5;
   logic [NUM_PAIR-1:0] hit;

   logic valid_ff, overlap_ff;

   assign busy   = 1'b0;        // a new pair is taken every cycle
   assign accept = start && !busy;

   assign ax = '{req_a_x0, req_a_x1, req_a_x2};
   assign ay = '{req_a_y0, req_a_y1, req_a_y2};
   assign bx = '{req_b_x0, req_b_x1, req_b_x2};
   assign by = '{req_b_y0, req_b_y1, req_b_y2};

   tec_diff #(.COORD_BITS(COORD_BITS)) u_diff (
      .clock, .reset, .valid_in(accept),
      .ax, .ay, .bx, .by,
      .valid_out(v1), .eax, .eay, .ebx, .eby, .dx, .dy
   );

   tec_prod #(.COORD_BITS(COORD_BITS)) u_prod (
      .clock, .reset, .valid_in(v1),
      .eax, .eay, .ebx, .eby, .dx, .dy,
      .valid_out(v3), .dsq, .lim, .left_a, .right_b
   );

   tec_skip #(.COORD_BITS(COORD_BITS)) u_skip (
      .clock, .reset, .valid_in(v3),
      .dsq, .lim, .left_a, .right_b,
      .valid_out(v5), .hit
   );

   // final stage: any pair crossing sets overlap
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= v5;
      end
   end

   always_ff @(posedge clock) begin
      overlap_ff <= |hit;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_overlap = overlap_ff;

   // a result strobe never follows directly out of reset
   a_reset_clears : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

   // result strobe is the last internal stage's valid, registered
   a_valid_track : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_valid == $past(v5)))
      else $error("result strobe out of step with pipeline");

   // any crossing pair must show up as a reported overlap
   a_overlap_src : assert property (@(posedge clock) disable iff (reset)
      (v5 && !$past(reset) && (hit != '0)) |=> rsp_overlap)
      else $error("crossing pair lost at output");
endmodule
`default_nettype wire
